@@ hw/rtl/dlol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlol_pkg
// shared opcodes, status codes, state type and control structs of the
// doubly linked order list
// ----------------------------------------------------------------------------
package dlol_pkg;

  localparam int unsigned DefaultEntries = 256;

  localparam logic [3:0] OpInsHead   = 4'd0;
  localparam logic [3:0] OpInsTail   = 4'd1;
  localparam logic [3:0] OpInsAfter  = 4'd2;
  localparam logic [3:0] OpInsBefore = 4'd3;
  localparam logic [3:0] OpDelete    = 4'd4;
  localparam logic [3:0] OpToHead    = 4'd5;
  localparam logic [3:0] OpToTail    = 4'd6;
  localparam logic [3:0] OpRmHead    = 4'd7;
  localparam logic [3:0] OpRmTail    = 4'd8;
  localparam logic [3:0] OpClear     = 4'd9;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatEmpty  = 2'd1;
  localparam logic [1:0] StatReject = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_PREP = 8'b0000_1000,
    S_LA   = 8'b0001_0000,
    S_LB   = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } dlol_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic read;
    logic unlink;
    logic prep;
    logic link_a;
    logic link_b;
    logic clear;
    logic finish;
  } dlol_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reject;
    logic empty;
    logic noop;
    logic is_clear;
    logic needs_read;
    logic does_unlink;
    logic does_link;
    logic out_busy;
  } dlol_stat_t;

endpackage

@@ hw/rtl/doubly_linked_order_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_order_list
// doubly linked ordering list over a fixed pool of entries, for lru tracking
// ----------------------------------------------------------------------------
// Each transaction applies one opcode (insert at head, tail, after or before
// a listed entry, delete, move to head or tail, remove head or tail, clear)
// and returns one result with status, removed entry, count, head and tail.
// The next and prior links sit in two memories with one write port each, so
// a transaction passes only the steps its opcode needs: a rejected operation,
// empty remove, no-op or clear goes from decode straight to done, delete or
// remove adds the link read and unlink, a head or tail insert adds neighbor
// prep and the link writes, a relative insert or a move adds both. A new
// transaction is taken once the previous result is in the output register.
// Membership bits reset at once, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module doubly_linked_order_list #(
  parameter int unsigned ENTRIES = dlol_pkg::DefaultEntries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request side
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] opcode_i,
  input  logic [7:0] entry_i,
  input  logic [7:0] ref_entry_i,
  // result side
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] out_entry_o,
  output logic [8:0] count_o,
  output logic [7:0] head_entry_o,
  output logic [7:0] tail_entry_o
);
  import dlol_pkg::*;

  dlol_cmd_t  cmd;
  dlol_stat_t stat;

  // sequencer
  dlol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // link storage and list registers
  dlol_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .entry_i      (entry_i),
    .ref_entry_i  (ref_entry_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_entry_o  (out_entry_o),
    .count_o      (count_o),
    .head_entry_o (head_entry_o),
    .tail_entry_o (tail_entry_o)
  );

endmodule

@@ hw/rtl/dlol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlol_ctrl
// sequencer that steps one list operation through decode, link read,
// unlink, neighbor prep and the two relink writes
// ----------------------------------------------------------------------------
module dlol_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlol_pkg::dlol_stat_t stat_i,
  output dlol_pkg::dlol_cmd_t  cmd_o
);
  import dlol_pkg::*;

  dlol_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.decode = 1'b1;
        if (stat_i.reject || stat_i.empty || stat_i.noop) begin
          state_d = S_DONE;
        end else if (stat_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_DONE;
        end else if (stat_i.needs_read) begin
          cmd_o.read = 1'b1;
          state_d    = S_RD;
        end else begin
          state_d = S_PREP;
        end
      end
      S_RD: begin
        cmd_o.unlink = stat_i.does_unlink;
        state_d      = stat_i.does_link ? S_PREP : S_DONE;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_LA;
      end
      S_LA: begin
        cmd_o.link_a = 1'b1;
        state_d      = S_LB;
      end
      S_LB: begin
        cmd_o.link_b = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/dlol_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlol_dp
// link memories, membership bits, head, tail, count and result register
// ----------------------------------------------------------------------------
module dlol_dp #(
  parameter int unsigned ENTRIES = dlol_pkg::DefaultEntries
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           opcode_i,
  input  logic [7:0]           entry_i,
  input  logic [7:0]           ref_entry_i,
  input  dlol_pkg::dlol_cmd_t  cmd_i,
  output dlol_pkg::dlol_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [7:0]           out_entry_o,
  output logic [8:0]           count_o,
  output logic [7:0]           head_entry_o,
  output logic [7:0]           tail_entry_o
);
  import dlol_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NullLink = LW'(ENTRIES);

  logic [LW-1:0] next_mem  [ENTRIES];
  logic [LW-1:0] prior_mem [ENTRIES];
  logic [LW-1:0] nx_rd_q, pr_rd_q;

  logic [ENTRIES-1:0] member_q;
  logic [LW-1:0]      head_q, tail_q, count_q;
  logic [3:0]         op_q;
  logic [7:0]         e_q, r_q;
  logic [LW-1:0]      victim_q, p_q, n_q;
  logic               reject_q, empty_q;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [7:0]    out_entry_q;
  logic [8:0]    count_out_q;
  logic [7:0]    head_out_q, tail_out_q;

  logic          e_ok, r_ok, e_listed, r_listed;
  logic [LW-1:0] e_link, r_link, victim;
  logic [IW-1:0] rd_addr;

  logic          nx_we, pr_we;
  logic [IW-1:0] nx_wa, pr_wa;
  logic [LW-1:0] nx_wd, pr_wd;
  logic [LW-1:0] p_sel, n_sel;

  assign e_ok     = 32'(e_q) < ENTRIES;
  assign r_ok     = 32'(r_q) < ENTRIES;
  assign e_listed = e_ok && member_q[IW'(e_q)];
  assign r_listed = r_ok && member_q[IW'(r_q)];
  assign e_link   = LW'(e_q);
  assign r_link   = LW'(r_q);

  // decode of the held transaction
  always_comb begin
    stat_o          = '0;
    stat_o.out_busy = out_valid_q && out_stall_i;
    victim          = e_link;
    case (op_q)
      OpInsHead, OpInsTail: begin
        stat_o.reject    = !e_ok || e_listed;
        stat_o.does_link = 1'b1;
      end
      OpInsAfter, OpInsBefore: begin
        stat_o.reject     = !e_ok || e_listed || !r_listed;
        stat_o.needs_read = 1'b1;
        stat_o.does_link  = 1'b1;
      end
      OpDelete: begin
        stat_o.reject      = !e_listed;
        stat_o.needs_read  = 1'b1;
        stat_o.does_unlink = 1'b1;
      end
      OpToHead: begin
        stat_o.reject      = !e_listed;
        stat_o.noop        = head_q == e_link;
        stat_o.needs_read  = 1'b1;
        stat_o.does_unlink = 1'b1;
        stat_o.does_link   = 1'b1;
      end
      OpToTail: begin
        stat_o.reject      = !e_listed;
        stat_o.noop        = tail_q == e_link;
        stat_o.needs_read  = 1'b1;
        stat_o.does_unlink = 1'b1;
        stat_o.does_link   = 1'b1;
      end
      OpRmHead: begin
        victim             = head_q;
        stat_o.empty       = (count_q == '0) || (head_q == NullLink);
        stat_o.needs_read  = 1'b1;
        stat_o.does_unlink = 1'b1;
      end
      OpRmTail: begin
        victim             = tail_q;
        stat_o.empty       = (count_q == '0) || (tail_q == NullLink);
        stat_o.needs_read  = 1'b1;
        stat_o.does_unlink = 1'b1;
      end
      OpClear: begin
        stat_o.is_clear = 1'b1;
      end
      default: begin
        stat_o.noop = 1'b1;
      end
    endcase
  end

  assign rd_addr = (op_q == OpInsAfter || op_q == OpInsBefore) ? IW'(r_q) : IW'(victim);

  // neighbors of the entry being linked in
  always_comb begin
    case (op_q)
      OpInsHead, OpToHead: begin
        p_sel = NullLink;
        n_sel = head_q;
      end
      OpInsAfter: begin
        p_sel = r_link;
        n_sel = nx_rd_q;
      end
      OpInsBefore: begin
        p_sel = pr_rd_q;
        n_sel = r_link;
      end
      default: begin
        p_sel = tail_q;
        n_sel = NullLink;
      end
    endcase
  end

  // one write per link memory per cycle
  always_comb begin
    nx_we = 1'b0;
    pr_we = 1'b0;
    nx_wa = IW'(pr_rd_q);
    nx_wd = nx_rd_q;
    pr_wa = IW'(nx_rd_q);
    pr_wd = pr_rd_q;
    if (cmd_i.unlink) begin
      nx_we = pr_rd_q != NullLink;
      pr_we = nx_rd_q != NullLink;
    end else if (cmd_i.link_a) begin
      nx_we = p_q != NullLink;
      nx_wa = IW'(p_q);
      nx_wd = e_link;
      pr_we = 1'b1;
      pr_wa = IW'(e_q);
      pr_wd = p_q;
    end else if (cmd_i.link_b) begin
      nx_we = 1'b1;
      nx_wa = IW'(e_q);
      nx_wd = n_q;
      pr_we = n_q != NullLink;
      pr_wa = IW'(n_q);
      pr_wd = e_link;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pr_we) begin
      prior_mem[pr_wa] <= pr_wd;
    end
    if (cmd_i.read) begin
      nx_rd_q <= next_mem[rd_addr];
      pr_rd_q <= prior_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= opcode_i;
      e_q  <= entry_i;
      r_q  <= ref_entry_i;
    end
    // outcome is fixed at decode, before the list changes
    if (cmd_i.decode) begin
      reject_q <= stat_o.reject;
      empty_q  <= stat_o.empty;
    end
    if (cmd_i.read) begin
      victim_q <= victim;
    end
    if (cmd_i.prep) begin
      p_q <= p_sel;
      n_q <= n_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q <= '0;
      head_q   <= NullLink;
      tail_q   <= NullLink;
      count_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        member_q <= '0;
        head_q   <= NullLink;
        tail_q   <= NullLink;
        count_q  <= '0;
      end
      if (cmd_i.unlink) begin
        if (pr_rd_q == NullLink) begin
          head_q <= nx_rd_q;
        end
        if (nx_rd_q == NullLink) begin
          tail_q <= pr_rd_q;
        end
        member_q[IW'(victim_q)] <= 1'b0;
        count_q <= count_q - LW'(1);
      end
      if (cmd_i.link_a && p_q == NullLink) begin
        head_q <= e_link;
      end
      if (cmd_i.link_b) begin
        if (n_q == NullLink) begin
          tail_q <= e_link;
        end
        member_q[IW'(e_q)] <= 1'b1;
        count_q <= count_q + LW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (reject_q) begin
        status_q <= StatReject;
      end else if (empty_q) begin
        status_q <= StatEmpty;
      end else begin
        status_q <= StatOk;
      end
      out_entry_q <= ((op_q == OpRmHead || op_q == OpRmTail) && !empty_q)
                     ? 8'(victim_q) : 8'd0;
      count_out_q <= 9'(count_q);
      head_out_q  <= (count_q != '0 && head_q != NullLink) ? 8'(head_q) : 8'd0;
      tail_out_q  <= (count_q != '0 && tail_q != NullLink) ? 8'(tail_q) : 8'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_entry_o  = out_entry_q;
  assign count_o      = count_out_q;
  assign head_entry_o = head_out_q;
  assign tail_entry_o = tail_out_q;

endmodule
